@@ rtl/fvc_pkg.sv @@
// Shared types, constants and tables for the target-following speed command block.
package fvc_pkg;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic               tracking_enabled;
  } in_t;

  typedef struct packed {
    logic signed [15:0] lin_x;
    logic signed [15:0] lin_y;
    logic signed [15:0] ang_z;
    logic [1:0]         mode;
  } out_t;

  // register indexes
  localparam logic [1:0] REG_STOP_DIST   = 2'd0;
  localparam logic [1:0] REG_MAX_LIN_VEL = 2'd1;
  localparam logic [1:0] REG_MAX_ANG_VEL = 2'd2;

  // status codes
  localparam logic [1:0] MODE_TRACK = 2'd0;
  localparam logic [1:0] MODE_CLOSE = 2'd1;
  localparam logic [1:0] MODE_IDLE  = 2'd2;

  localparam int PI_Q16     = 205887;
  localparam int LN2_Q16    = 45426;
  localparam int OFFSET_Q16 = 19661;
  localparam int GAUSS_C    = 83664;
  localparam int CLOSE_ANG  = 6553;
  localparam int SAT_W      = 1638404;   // e > 5.0 once (u^2+half)>>16 exceeds this
  localparam int NUM_ITER   = 16;
  localparam int NUM_TERMS  = 12;

  // ceiling reciprocals 2^32/n rounded up; quotient is exact or one high
  localparam longint unsigned RECIP5  = 64'd858993460;
  localparam longint unsigned RECIP13 = 64'd330382100;

  // pipeline stage indexes (stage 0 is the first register after the input)
  localparam int LAT       = 44;
  localparam int CORD_IDX  = 16;
  localparam int ANG_IDX   = 19;
  localparam int ANG_DLY   = LAT - ANG_IDX;
  localparam int KS_DEPTH  = NUM_TERMS * 3 + 2;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [19:0] z;
  } cordic_t;

  typedef struct packed {
    logic [30:0] term;
    logic [31:0] sum;
    logic [15:0] r;
  } exp_t;

  typedef struct packed {
    logic track;
    logic tx_pos;
    logic ty_neg;
    logic ang_zero;
    logic cmd_zero;
  } meta_t;

  typedef struct packed {
    logic signed [15:0] az_close;
    logic [14:0]        wmag;
    logic               wneg;
  } ang_t;

  function automatic logic [19:0] atan_q16(input int i);
    logic [19:0] v;
    case (i)
      0:  v = 20'd51472;
      1:  v = 20'd30385;
      2:  v = 20'd16055;
      3:  v = 20'd8150;
      4:  v = 20'd4091;
      5:  v = 20'd2047;
      6:  v = 20'd1024;
      7:  v = 20'd512;
      8:  v = 20'd256;
      9:  v = 20'd128;
      10: v = 20'd64;
      11: v = 20'd32;
      12: v = 20'd16;
      13: v = 20'd8;
      14: v = 20'd4;
      15: v = 20'd2;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/fvc_cordic_cell.sv @@
// One vectoring CORDIC iteration with its own output register.
module fvc_cordic_cell #(
  parameter int Iter = 0
) (
  input  logic              clk,
  input  logic              en,
  input  fvc_pkg::cordic_t  cin,
  output fvc_pkg::cordic_t  cout
);

  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [19:0] step;

  assign xs   = cin.x >>> Iter;
  assign ys   = cin.y >>> Iter;
  assign step = signed'(fvc_pkg::atan_q16(Iter));

  always_ff @(posedge clk) begin
    if (en) begin
      if (cin.y > 0) begin
        cout.x <= cin.x + ys;
        cout.y <= cin.y - xs;
        cout.z <= cin.z + step;
      end else begin
        cout.x <= cin.x - ys;
        cout.y <= cin.y + xs;
        cout.z <= cin.z - step;
      end
    end
  end

endmodule

@@ rtl/fvc_exp_cell.sv @@
// One Taylor term of exp(r): term = floor(floor(term*r/2^16)/N), sum += term.
module fvc_exp_cell #(
  parameter int N = 1
) (
  input  logic           clk,
  input  logic           en,
  input  fvc_pkg::exp_t  cin,
  output fvc_pkg::exp_t  cout
);

  localparam bit Pow2 = (N & (N - 1)) == 0;
  localparam int Sh   = $clog2(N);
  localparam longint unsigned Recip = ((64'd1 << 32) + 64'(N) - 64'd1) / 64'(N);

  logic [46:0] prod_a;
  logic [30:0] p_a;
  logic [31:0] sum_a;
  logic [15:0] r_a;
  logic [30:0] q0_c;
  logic [30:0] q0_b;
  logic [30:0] p_b;
  logic [31:0] sum_b;
  logic [15:0] r_b;
  logic [34:0] back;
  logic [30:0] q;

  // r carries 16 fraction bits, 14 less than the Q30 term, so shift by 16
  assign prod_a = 47'(cin.term) * 47'(cin.r);

  always_ff @(posedge clk) begin
    if (en) begin
      p_a   <= prod_a[46:16];
      sum_a <= cin.sum;
      r_a   <= cin.r;
    end
  end

  generate
    if (Pow2) begin : g_shift
      assign q0_c = p_a >> Sh;
    end else begin : g_recip
      logic [62:0] prod_b;
      assign prod_b = 63'(p_a) * 63'(Recip);
      assign q0_c   = prod_b[62:32];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      q0_b  <= q0_c;
      p_b   <= p_a;
      sum_b <= sum_a;
      r_b   <= r_a;
    end
  end

  assign back = 35'(q0_b) * 35'(N);
  assign q    = (back > 35'(p_b)) ? q0_b - 31'd1 : q0_b;

  always_ff @(posedge clk) begin
    if (en) begin
      cout.term <= q;
      cout.sum  <= sum_b + 32'(q);
      cout.r    <= r_b;
    end
  end

endmodule

@@ rtl/fvc_gauss.sv @@
// Gaussian speed lane: g(v) = exp((v-0.3)^2/5)/(5*sqrt(2*pi)) in Q3.12, saturated.
module fvc_gauss (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] v,
  output logic [14:0]        g
);

  localparam int KsLast = fvc_pkg::KS_DEPTH - 1;

  logic signed [24:0] u;
  logic [23:0]        a1;
  logic [47:0]        a2;
  logic [48:0]        wsum;
  logic [20:0]        w3;
  logic               sat3;
  logic [50:0]        prod4;
  logic [18:0]        q4;
  logic [20:0]        w4;
  logic               sat4;
  logic [21:0]        back5;
  logic [18:0]        e5;
  logic               sat5;
  logic [2:0]         k_c;
  logic [15:0]        r_c;
  logic [3:0]         ks [KsLast:0];
  fvc_pkg::exp_t      ex0;
  fvc_pkg::exp_t      ex [fvc_pkg::NUM_TERMS:0];
  logic [48:0]        p43;
  logic [56:0]        sh;
  logic [18:0]        q44;

  assign u = signed'({v[15], v, 8'h00}) - 25'sd19661;

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= u[24] ? 24'(-u) : u[23:0];
      a2 <= 48'(a1) * 48'(a1);
    end
  end

  assign wsum = 49'(a2) + 49'd163840;

  always_ff @(posedge clk) begin
    if (en) begin
      sat3 <= wsum[48:16] > 33'(fvc_pkg::SAT_W);
      w3   <= wsum[36:16];
    end
  end

  assign prod4 = 51'(w3) * 51'(fvc_pkg::RECIP5);

  always_ff @(posedge clk) begin
    if (en) begin
      q4   <= prod4[50:32];
      w4   <= w3;
      sat4 <= sat3;
    end
  end

  assign back5 = 22'(q4) * 22'd5;

  always_ff @(posedge clk) begin
    if (en) begin
      e5   <= (back5 > 22'(w4)) ? q4 - 19'd1 : q4;
      sat5 <= sat4;
    end
  end

  // split e into k*ln2 + r
  always_comb begin
    k_c = 3'd0;
    for (int j = 1; j <= 7; j++) begin
      if (e5 >= 19'(j * fvc_pkg::LN2_Q16)) k_c = 3'(j);
    end
    r_c = 16'(e5 - 19'(k_c) * 19'(fvc_pkg::LN2_Q16));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex0.term <= 31'h4000_0000;
      ex0.sum  <= 32'h4000_0000;
      ex0.r    <= r_c;
      ks[0]    <= {k_c, sat5};
      for (int i = 1; i <= KsLast; i++) ks[i] <= ks[i-1];
    end
  end

  assign ex[0] = ex0;

  genvar n;
  generate
    for (n = 1; n <= fvc_pkg::NUM_TERMS; n++) begin : g_term
      fvc_exp_cell #(.N(n)) u_term (
        .clk  (clk),
        .en   (en),
        .cin  (ex[n-1]),
        .cout (ex[n])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      p43 <= 49'(ex[fvc_pkg::NUM_TERMS].sum) * 49'(fvc_pkg::GAUSS_C);
    end
  end

  // Q30 * Q20 -> Q12, round half up
  assign sh  = (57'(p43) << ks[KsLast][3:1]) + (57'd1 << 37);
  assign q44 = sh[56:38];

  always_ff @(posedge clk) begin
    if (en) begin
      g <= (ks[KsLast][0] || q44 > 19'd32767) ? 15'h7fff : q44[14:0];
    end
  end

endmodule

@@ rtl/follow_target_velocity_command.sv @@
// Top level: target-following speed command pipeline with config registers.
// One item enters per clock while in_ready is high; it passes 44 pipeline
// stages, the first loaded at the accepting edge, then a two-entry output
// buffer that offers its command. The depth is set by the exponential chain:
// twelve Taylor cells of three registers each in both speed lanes, running
// beside a sixteen-cell CORDIC angle chain. in_ready drops only while the
// output buffer holds two undelivered items. A new stop distance applies to
// items accepted on the cycle after the write; the speed limits act at the last
// stage, so the user must write config only while no item is in flight; the block itself does not enforce this.
module follow_target_velocity_command (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fvc_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output fvc_pkg::out_t   out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [14:0]     cfg_data
);

  logic [14:0] stop_dist;
  logic [14:0] max_lin_vel;
  logic [14:0] max_ang_vel;
  logic [29:0] s2;

  logic                   en;
  logic [fvc_pkg::LAT-1:0] vld;
  fvc_pkg::meta_t         mq [fvc_pkg::LAT-1:0];
  logic [fvc_pkg::LAT-1:1] cl;
  logic [33:0]            dx2;
  logic [33:0]            dy2;
  logic signed [16:0]     dx;
  logic signed [16:0]     dy;
  logic signed [33:0]     dxx;
  logic signed [33:0]     dyy;
  fvc_pkg::meta_t         meta_in;
  fvc_pkg::cordic_t       cord_in;
  fvc_pkg::cordic_t       cd0;
  fvc_pkg::cordic_t       cd [fvc_pkg::NUM_ITER:0];
  logic signed [32:0]     x0;
  logic signed [32:0]     y0;

  logic signed [19:0]     ang;
  logic [18:0]            mag;
  logic [14:0]            m32;
  logic signed [15:0]     azc;
  logic [22:0]            hsum;
  logic signed [15:0]     azc18;
  logic [18:0]            h18;
  logic                   wneg18;
  logic [47:0]            prod19;
  logic [15:0]            q19;
  logic [18:0]            h19;
  logic signed [15:0]     azc19;
  logic                   wneg19;
  logic [20:0]            back20;
  fvc_pkg::ang_t          ad [fvc_pkg::ANG_DLY-1:0];

  logic [14:0]            gx;
  logic [14:0]            gy;
  logic [14:0]            vx;
  logic [14:0]            vy;
  logic [14:0]            wc;
  fvc_pkg::meta_t         mf;
  fvc_pkg::ang_t          af;
  fvc_pkg::out_t          res;

  logic [1:0]             count;
  fvc_pkg::out_t          buf0;
  fvc_pkg::out_t          buf1;
  logic                   push;
  logic                   pop;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_dist   <= 15'd128;
      max_lin_vel <= 15'd2048;
      max_ang_vel <= 15'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        fvc_pkg::REG_STOP_DIST:   stop_dist   <= cfg_data;
        fvc_pkg::REG_MAX_LIN_VEL: max_lin_vel <= cfg_data;
        fvc_pkg::REG_MAX_ANG_VEL: max_ang_vel <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s2 <= 30'(stop_dist) * 30'(stop_dist);
  end

  assign en       = (count != 2'd2);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[fvc_pkg::LAT-2:0], in_valid};
    end
  end

  // stage 0: flags, distance squares, CORDIC setup
  assign dx  = 17'(in_data.goal_x) - 17'(in_data.robot_x);
  assign dy  = 17'(in_data.goal_y) - 17'(in_data.robot_y);
  assign dxx = 34'(dx) * 34'(dx);
  assign dyy = 34'(dy) * 34'(dy);

  always_comb begin
    meta_in.track    = in_data.tracking_enabled;
    meta_in.tx_pos   = in_data.target_x > 0;
    meta_in.ty_neg   = in_data.target_y < 0;
    meta_in.ang_zero = (in_data.target_x == 0) && (in_data.target_y == 0);
    meta_in.cmd_zero = (in_data.target_x == 0) ||
                       ((in_data.target_y == 0) && (in_data.target_x > 0));
  end

  assign x0 = 33'(in_data.target_x) <<< 14;
  assign y0 = 33'(in_data.target_y) <<< 14;

  // left half-plane: rotate by pi first
  always_comb begin
    if (in_data.target_x < 0) begin
      cord_in.x = -x0;
      cord_in.y = -y0;
      cord_in.z = (in_data.target_y >= 0) ? 20'sd205887 : -20'sd205887;
    end else begin
      cord_in.x = x0;
      cord_in.y = y0;
      cord_in.z = 20'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd0   <= cord_in;
      dx2   <= dxx;
      dy2   <= dyy;
      mq[0] <= meta_in;
      for (int i = 1; i < fvc_pkg::LAT; i++) mq[i] <= mq[i-1];
      cl[1] <= (35'(dx2) + 35'(dy2)) < 35'(s2);
      for (int i = 2; i < fvc_pkg::LAT; i++) cl[i] <= cl[i-1];
    end
  end

  assign cd[0] = cd0;

  genvar it;
  generate
    for (it = 0; it < fvc_pkg::NUM_ITER; it++) begin : g_iter
      fvc_cordic_cell #(.Iter(it)) u_cell (
        .clk  (clk),
        .en   (en),
        .cin  (cd[it]),
        .cout (cd[it+1])
      );
    end
  endgenerate

  // angle post-processing: close-range turn and tracking yaw magnitude
  assign ang  = mq[fvc_pkg::CORD_IDX].ang_zero ? 20'sd0 : cd[fvc_pkg::NUM_ITER].z;
  assign mag  = ang[19] ? 19'(-ang) : 19'(ang);
  assign m32  = 15'((20'(mag) + 20'd16) >> 5);
  assign azc  = (mag > 19'(fvc_pkg::CLOSE_ANG)) ?
                (ang[19] ? -16'(signed'({1'b0, m32})) : 16'(signed'({1'b0, m32}))) :
                16'sd0;
  assign hsum = 23'(mag) * 23'd10 + 23'd104;

  always_ff @(posedge clk) begin
    if (en) begin
      azc18  <= azc;
      h18    <= hsum[22:4];
      wneg18 <= ang > 0;
    end
  end

  assign prod19 = 48'(h18) * 48'(fvc_pkg::RECIP13);

  always_ff @(posedge clk) begin
    if (en) begin
      q19    <= prod19[47:32];
      h19    <= h18;
      azc19  <= azc18;
      wneg19 <= wneg18;
    end
  end

  assign back20 = 21'(q19) * 21'd13;

  always_ff @(posedge clk) begin
    if (en) begin
      ad[0].az_close <= azc19;
      ad[0].wmag     <= (back20 > 21'(h19)) ? 15'(q19 - 16'd1) : 15'(q19);
      ad[0].wneg     <= wneg19;
      for (int i = 1; i < fvc_pkg::ANG_DLY; i++) ad[i] <= ad[i-1];
    end
  end

  fvc_gauss u_gauss_x (
    .clk (clk),
    .en  (en),
    .v   (in_data.target_x),
    .g   (gx)
  );

  fvc_gauss u_gauss_y (
    .clk (clk),
    .en  (en),
    .v   (in_data.target_y),
    .g   (gy)
  );

  // final selection
  assign mf = mq[fvc_pkg::LAT-1];
  assign af = ad[fvc_pkg::ANG_DLY-1];
  assign vx = (gx > max_lin_vel) ? max_lin_vel : gx;
  assign vy = (gy > max_lin_vel) ? max_lin_vel : gy;
  assign wc = (af.wmag > max_ang_vel) ? max_ang_vel : af.wmag;

  always_comb begin
    res.lin_x = 16'sd0;
    res.lin_y = 16'sd0;
    res.ang_z = 16'sd0;
    if (cl[fvc_pkg::LAT-1]) begin
      res.mode  = fvc_pkg::MODE_CLOSE;
      res.ang_z = af.az_close;
    end else if (!mf.track) begin
      res.mode = fvc_pkg::MODE_IDLE;
    end else begin
      res.mode = fvc_pkg::MODE_TRACK;
      if (!mf.cmd_zero) begin
        res.lin_x = mf.tx_pos ? signed'({1'b0, vx}) : -signed'({1'b0, vx});
        res.lin_y = mf.ty_neg ? -signed'({1'b0, vy}) : signed'({1'b0, vy});
        res.ang_z = af.wneg ? -signed'({1'b0, wc}) : signed'({1'b0, wc});
      end
    end
  end

  // two-entry output buffer
  assign push      = en && vld[fvc_pkg::LAT-1];
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_data  = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: if (push) count <= 2'd1;
        2'd1: if (pop && !push) count <= 2'd0;
              else if (push && !pop) count <= 2'd2;
        2'd2: if (pop) count <= 2'd1;
        default: count <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: if (push) buf0 <= res;
      2'd1: begin
        if (push && pop) buf0 <= res;
        else if (push) buf1 <= res;
      end
      2'd2: if (pop) buf0 <= buf1;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output buffer count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && count == 2'd2))
    else $error("result pushed into full buffer");
  a_close_no_lin: assert property (@(posedge clk) disable iff (rst)
    (push && res.mode == fvc_pkg::MODE_CLOSE) |-> (res.lin_x == 0 && res.lin_y == 0))
    else $error("linear speed while too close");
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (push && res.mode == fvc_pkg::MODE_IDLE) |-> (res.ang_z == 0))
    else $error("yaw rate while inactive");
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !out_ready) |=> (count == 2'd2 && $stable(buf0)))
    else $error("buffered item lost under stall");
`endif

endmodule
